### src/signed_binary_to_decimal_ascii_core_assert.svh
// Assertion macros shared by the RTL.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Clocked check, off while reset is held.
`define SBDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SBDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/sbda_pkg.sv
package sbda_pkg;

    localparam int NUM_DIGITS = 5;

    localparam logic [5:0] CH_PLUS  = 6'd43;
    localparam logic [5:0] CH_MINUS = 6'd45;
    localparam logic [5:0] CH_ZERO  = 6'd48;

    localparam logic [7:0] RECIP_CD = 8'hCD;
    localparam logic [7:0] RECIP_1A = 8'h1A;

    // digits, index 0 is the most significant place
    typedef logic [NUM_DIGITS-1:0][7:0] t_digits;
    typedef logic [NUM_DIGITS-1:0][5:0] t_chars;

    // x / 10 for x < 256: (x * 0xCD) >> 11
    function automatic logic [7:0] div10_cd(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'(RECIP_CD);
        return {3'b000, p[15:11]};
    endfunction

    // coarse x / 10: (x * 0x1A) >> 8
    function automatic logic [7:0] div10_1a(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'(RECIP_1A);
        return p[15:8];
    endfunction

    // x - 10 * q, wrapping at 8 bits
    function automatic logic [7:0] sub_ten(input logic [7:0] x, input logic [7:0] q);
        logic [7:0] t;
        t = {q[4:0], 3'b000} + {q[6:0], 1'b0};
        return x - t;
    endfunction

endpackage

### src/sbda_format.sv
module sbda_format
    import sbda_pkg::*;
(
    input  t_digits    i_digits,
    output t_chars     o_chars,
    output logic [2:0] o_count
);

    logic [2:0] lead;
    logic [2:0] idx;

    always_comb begin
        // first nonzero among the top four places; the last place is always kept
        lead = 3'd4;
        for (int k = NUM_DIGITS - 2; k >= 0; k--) begin
            if (i_digits[k] != 8'd0) begin
                lead = 3'(k);
            end
        end
        o_count = 3'(NUM_DIGITS) - lead;

        o_chars = '0;
        idx     = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            idx = lead + 3'(k);
            if (3'(k) < o_count) begin
                o_chars[k] = i_digits[idx][5:0] + CH_ZERO;
            end
        end
    end

endmodule

### src/signed_binary_to_decimal_ascii_core.sv
// Signed 16-bit binary to decimal ASCII converter.
//
// Input: drive i_value and raise start; the item is taken at a rising edge
// where start is high and busy is low. busy is always low, so one item may
// be taken every cycle.
// Output: each item gives one result, shown for exactly one cycle with
// o_done high: a sign character ('+' or '-'), up to five ASCII digits with
// leading zeros dropped (at least one digit is kept), and o_digit_count.
// Character ports past the count read 0. -32768 converts to "-32768".
// Each item passes through six register stages (magnitude, low place,
// second place, third place, top places, format), and the pipeline takes
// one item per cycle as busy never rises.
// Reset clears all stage valid bits; items in flight are dropped and no
// result is shown until a new item passes. The receiver cannot stall, so
// no result is ever held back.
module signed_binary_to_decimal_ascii_core
    import sbda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [15:0] i_value,
    output logic        busy,
    output logic        o_done,
    output logic [5:0]  o_sign_char,
    output logic [5:0]  o_char_first,
    output logic [5:0]  o_char_second,
    output logic [5:0]  o_char_third,
    output logic [5:0]  o_char_fourth,
    output logic [5:0]  o_char_fifth,
    output logic [2:0]  o_digit_count
);

    `include "signed_binary_to_decimal_ascii_core_assert.svh"

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    // stage 1: sign and magnitude
    logic        r1_neg;
    logic [15:0] r1_mag;
    logic [15:0] n1_mag;

    // stage 2: units place
    logic       r2_neg;
    logic [3:0] r2_n3, r2_n2, r2_n1;
    logic [7:0] r2_d0, r2_q;
    logic [7:0] n2_sum, n2_q;

    // stage 3: tens place
    logic       r3_neg;
    logic [3:0] r3_n3, r3_n2;
    logic [7:0] r3_d0, r3_d1, r3_q;
    logic [7:0] n3_sum, n3_q;

    // stage 4: hundreds place
    logic       r4_neg;
    logic [3:0] r4_n3;
    logic [7:0] r4_d0, r4_d1, r4_d2, r4_q;
    logic [7:0] n4_sum, n4_q;

    // stage 5: thousands and ten-thousands
    logic       r5_neg;
    t_digits    r5_digits;
    logic [7:0] n5_sum, n5_q;

    // stage 6: output
    t_chars     n6_chars;
    logic [2:0] n6_count;
    t_chars     r6_chars;
    logic [2:0] r6_count;
    logic [5:0] r6_sign;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    assign n1_mag = i_value[15] ? (16'd0 - i_value) : i_value;

    always_ff @(posedge i_clk) begin
        r1_neg <= i_value[15];
        r1_mag <= n1_mag;
    end

    always_comb begin
        n2_sum = 8'd6 * (8'(r1_mag[15:12]) + 8'(r1_mag[11:8]) + 8'(r1_mag[7:4]))
               + 8'(r1_mag[3:0]);
        n2_q   = div10_cd(n2_sum);
    end

    always_ff @(posedge i_clk) begin
        r2_neg <= r1_neg;
        r2_n3  <= r1_mag[15:12];
        r2_n2  <= r1_mag[11:8];
        r2_n1  <= r1_mag[7:4];
        r2_d0  <= sub_ten(n2_sum, n2_q);
        r2_q   <= n2_q;
    end

    always_comb begin
        n3_sum = r2_q + 8'd9 * 8'(r2_n3) + 8'd5 * 8'(r2_n2) + 8'(r2_n1);
        n3_q   = div10_cd(n3_sum);
    end

    always_ff @(posedge i_clk) begin
        r3_neg <= r2_neg;
        r3_n3  <= r2_n3;
        r3_n2  <= r2_n2;
        r3_d0  <= r2_d0;
        r3_d1  <= sub_ten(n3_sum, n3_q);
        r3_q   <= n3_q;
    end

    always_comb begin
        n4_sum = r3_q + {3'b000, r3_n2, 1'b0};
        n4_q   = div10_1a(n4_sum);
    end

    always_ff @(posedge i_clk) begin
        r4_neg <= r3_neg;
        r4_n3  <= r3_n3;
        r4_d0  <= r3_d0;
        r4_d1  <= r3_d1;
        r4_d2  <= sub_ten(n4_sum, n4_q);
        r4_q   <= n4_q;
    end

    always_comb begin
        n5_sum = r4_q + {2'b00, r4_n3, 2'b00};
        n5_q   = div10_1a(n5_sum);
    end

    always_ff @(posedge i_clk) begin
        r5_neg       <= r4_neg;
        r5_digits[0] <= n5_q;
        r5_digits[1] <= sub_ten(n5_sum, n5_q);
        r5_digits[2] <= r4_d2;
        r5_digits[3] <= r4_d1;
        r5_digits[4] <= r4_d0;
    end

    sbda_format u_format (
        .i_digits (r5_digits),
        .o_chars  (n6_chars),
        .o_count  (n6_count)
    );

    always_ff @(posedge i_clk) begin
        r6_sign  <= r5_neg ? CH_MINUS : CH_PLUS;
        r6_chars <= n6_chars;
        r6_count <= n6_count;
    end

    assign o_done        = r_v6;
    assign o_sign_char   = r6_sign;
    assign o_char_first  = r6_chars[0];
    assign o_char_second = r6_chars[1];
    assign o_char_third  = r6_chars[2];
    assign o_char_fourth = r6_chars[3];
    assign o_char_fifth  = r6_chars[4];
    assign o_digit_count = r6_count;

    `SBDA_ASSERT(a_latency, start && !busy |-> ##6 o_done, "item did not come out six cycles later")
    `SBDA_ASSERT(a_sign, o_done |-> ((o_sign_char == CH_MINUS) == $past(i_value[15], 6)), "sign char does not match the input sign")
    `SBDA_ASSERT(a_count, o_done |-> (o_digit_count >= 3'd1 && o_digit_count <= 3'd5), "digit count out of range")
    `SBDA_ASSERT(a_short, o_done && o_digit_count == 3'd1 |-> (o_char_second == 6'd0 && o_char_fifth == 6'd0), "unused char positions not cleared")
    `SBDA_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_done, "result shown right after reset")

endmodule
